### rtl/sorted_timer_queue_defines.svh
// assertion macros for the sorted timer queue
// used by the top level; expects clk and rst_n in scope
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH

// clocked check, masked while reset is asserted
`define STQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define STQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/stq_pkg.sv
// shared types, sizes and codes for the sorted timer queue
// no dependencies
package stq_pkg;

  localparam int CAPACITY  = 16;
  localparam int ID_BITS   = 16;
  localparam int TIME_BITS = 32;
  localparam int DELAY_BITS = 24;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_DEL  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;
  localparam logic [1:0] REQ_RSVD = 2'd3;

  localparam logic [2:0] OUT_ADDED     = 3'd0;
  localparam logic [2:0] OUT_FULL      = 3'd1;
  localparam logic [2:0] OUT_DELETED   = 3'd2;
  localparam logic [2:0] OUT_NOT_FOUND = 3'd3;
  localparam logic [2:0] OUT_EXPIRED   = 3'd4;
  localparam logic [2:0] OUT_NONE      = 3'd5;

  typedef struct packed {
    logic [TIME_BITS-1:0] expire;
    logic [ID_BITS-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic                 push;
    logic [2:0]           outcome;
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] expire;
    logic                 last;
  } result_t;

  // table order: by expiry, then by id
  function automatic logic entry_before(entry_t a, entry_t b);
    if (a.expire != b.expire) begin
      return a.expire < b.expire;
    end
    return a.id < b.id;
  endfunction

endpackage

### rtl/stq_mem.sv
// timer table storage: one write port, one registered read port
// depends on stq_pkg
module stq_mem import stq_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/stq_ctrl.sv
// request sequencer: scans, shifts and emits entries of the timer table
// depends on stq_pkg and stq_mem
module stq_ctrl import stq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  input  logic [1:0]            req_type,
  input  logic [TIME_BITS-1:0]  now_time,
  input  logic [DELAY_BITS-1:0] delay,
  input  logic [ID_BITS-1:0]    target_id,
  input  logic [TIME_BITS-1:0]  target_expire,
  input  logic                  out_free,
  output logic                  ready,
  output result_t               res
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_MOVE_RD, S_MOVE_WR, S_PUT,
    S_EMIT_RD, S_EMIT, S_RESULT
  } state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           kind_r, kind_nxt;
  entry_t               key_r, key_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [CNT_W-1:0]     dst_r, dst_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [ID_BITS-1:0]   next_id_r, next_id_nxt;
  result_t              res_r, res_nxt;

  logic                 we, re;
  logic [IDX_W-1:0]     waddr, raddr;
  entry_t               wdata, rdata;
  logic [CNT_W-1:0]     src;
  logic [TIME_BITS:0]   sum;

  stq_mem u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  assign src = (kind_r == REQ_ADD) ? dst_r - CNT_W'(1) : dst_r + n_r;
  assign sum = {1'b0, now_time} + (TIME_BITS + 1)'(delay);

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    key_nxt     = key_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    n_nxt       = n_r;
    dst_nxt     = dst_r;
    count_nxt   = count_r;
    next_id_nxt = next_id_r;
    res_nxt     = res_r;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = dst_r[IDX_W-1:0];
    wdata       = rdata;
    raddr       = idx_r[IDX_W-1:0];
    ready       = (state_r == S_IDLE);
    res         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid && req_type != REQ_RSVD) begin
          kind_nxt = req_type;
          idx_nxt  = '0;
          state_nxt = S_SCAN_RD;
          unique case (req_type)
            REQ_ADD: begin
              key_nxt.expire = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
              key_nxt.id     = next_id_r;
              next_id_nxt    = next_id_r + ID_BITS'(1);
            end
            REQ_DEL: begin
              key_nxt.expire = target_expire;
              key_nxt.id     = target_id;
            end
            default: begin
              key_nxt.expire = now_time;
              key_nxt.id     = '0;
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        if (idx_r == count_r) begin
          // reached the end of the valid entries
          res_nxt = '0;
          res_nxt.last = 1'b1;
          if (kind_r == REQ_ADD) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              res_nxt.outcome = OUT_FULL;
              state_nxt = S_RESULT;
            end else begin
              pos_nxt = idx_r;
              dst_nxt = count_r;
              state_nxt = (count_r == idx_r) ? S_PUT : S_MOVE_RD;
            end
          end else if (kind_r == REQ_DEL) begin
            res_nxt.outcome = OUT_NOT_FOUND;
            state_nxt = S_RESULT;
          end else if (idx_r == '0) begin
            res_nxt.outcome = OUT_NONE;
            state_nxt = S_RESULT;
          end else begin
            n_nxt = idx_r;
            idx_nxt = '0;
            state_nxt = S_EMIT_RD;
          end
        end else begin
          re = 1'b1;
          state_nxt = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        state_nxt = S_SCAN_RD;
        idx_nxt = idx_r + CNT_W'(1);
        res_nxt = '0;
        res_nxt.last = 1'b1;
        if (kind_r == REQ_ADD) begin
          if (!entry_before(rdata, key_r)) begin
            idx_nxt = idx_r;
            if (rdata == key_r) begin
              // same id and expiry already queued
              res_nxt.outcome = OUT_ADDED;
              res_nxt.id      = key_r.id;
              res_nxt.expire  = key_r.expire;
              state_nxt = S_RESULT;
            end else if (count_r == CNT_W'(CAPACITY)) begin
              res_nxt.outcome = OUT_FULL;
              state_nxt = S_RESULT;
            end else begin
              pos_nxt = idx_r;
              dst_nxt = count_r;
              state_nxt = S_MOVE_RD;
            end
          end
        end else if (kind_r == REQ_DEL) begin
          if (rdata == key_r) begin
            n_nxt   = CNT_W'(1);
            dst_nxt = idx_r;
            state_nxt = (idx_r + CNT_W'(1) == count_r) ? S_MOVE_WR : S_MOVE_RD;
          end
        end else if (rdata.expire > key_r.expire) begin
          n_nxt = idx_r;
          idx_nxt = '0;
          state_nxt = (idx_r == '0) ? S_RESULT : S_EMIT_RD;
          res_nxt.outcome = OUT_NONE;
        end
      end

      S_MOVE_RD: begin
        re = 1'b1;
        raddr = src[IDX_W-1:0];
        state_nxt = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        if (kind_r == REQ_ADD) begin
          we = 1'b1;
          dst_nxt = dst_r - CNT_W'(1);
          state_nxt = (dst_r - CNT_W'(1) == pos_r) ? S_PUT : S_MOVE_RD;
        end else if (src < count_r) begin
          we = 1'b1;
          dst_nxt = dst_r + CNT_W'(1);
          state_nxt = (src + CNT_W'(1) < count_r) ? S_MOVE_RD : S_MOVE_WR;
        end else begin
          // compaction finished
          count_nxt = count_r - n_r;
          res_nxt = '0;
          res_nxt.last = 1'b1;
          res_nxt.outcome = OUT_DELETED;
          state_nxt = (kind_r == REQ_DEL) ? S_RESULT : S_IDLE;
        end
      end

      S_PUT: begin
        we = 1'b1;
        waddr = pos_r[IDX_W-1:0];
        wdata = key_r;
        count_nxt = count_r + CNT_W'(1);
        res_nxt = '0;
        res_nxt.outcome = OUT_ADDED;
        res_nxt.id      = key_r.id;
        res_nxt.expire  = key_r.expire;
        res_nxt.last    = 1'b1;
        state_nxt = S_RESULT;
      end

      S_EMIT_RD: begin
        re = 1'b1;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        res.push    = out_free;
        res.outcome = OUT_EXPIRED;
        res.id      = rdata.id;
        res.expire  = rdata.expire;
        res.last    = (idx_r + CNT_W'(1) == n_r);
        if (out_free) begin
          idx_nxt = idx_r + CNT_W'(1);
          if (idx_r + CNT_W'(1) == n_r) begin
            dst_nxt = '0;
            state_nxt = (n_r == count_r) ? S_MOVE_WR : S_MOVE_RD;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end

      S_RESULT: begin
        res = res_r;
        res.push = out_free;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      next_id_r <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
    end
    kind_r <= kind_nxt;
    key_r  <= key_nxt;
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    n_r    <= n_nxt;
    dst_r  <= dst_nxt;
    res_r  <= res_nxt;
  end

endmodule

### rtl/sorted_timer_queue.sv
// sorted timer queue top: sequencer, table memory, result register; needs stq_pkg, defines
// steps per request, results waiting while the output register is full: add/delete read and
//   check each entry examined, read and write each entry shifted, then an add puts its entry
//   and the result is given; tick checks entries alike, emits each expired entry, then shifts
//   the survivors down; a new request is taken only in idle, once the last one is finished
// reset: synchronous active-low rst_n empties the table and zeroes the id counter
`include "sorted_timer_queue_defines.svh"

module sorted_timer_queue import stq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_req_type,
  input  logic [TIME_BITS-1:0]  in_now_time,
  input  logic [DELAY_BITS-1:0] in_delay,
  input  logic [ID_BITS-1:0]    in_target_id,
  input  logic [TIME_BITS-1:0]  in_target_expire,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_outcome,
  output logic [ID_BITS-1:0]    out_timer_id,
  output logic [TIME_BITS-1:0]  out_timer_expire,
  output logic                  out_last
);

  logic    ready;
  logic    out_free;
  result_t res;

  logic                 out_valid_r;
  logic [2:0]           outcome_r;
  logic [ID_BITS-1:0]   id_r;
  logic [TIME_BITS-1:0] expire_r;
  logic                 last_r;

  // output register can take a new result when empty or draining this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !ready;

  stq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .req_valid(in_valid), .req_type(in_req_type), .now_time(in_now_time),
    .delay(in_delay), .target_id(in_target_id), .target_expire(in_target_expire),
    .out_free(out_free), .ready(ready), .res(res)
  );

  // output holding register, parts the sequencer from the consumer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res.push;
    end
    if (res.push) begin
      outcome_r <= res.outcome;
      id_r      <= res.id;
      expire_r  <= res.expire;
      last_r    <= res.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = outcome_r;
  assign out_timer_id     = id_r;
  assign out_timer_expire = expire_r;
  assign out_last         = last_r;

  // a result is only produced when the output register has room
  `STQ_ASSERT(a_push_room, res.push |-> out_free, "result pushed into a full output register")
  // a new request is never taken while a result is being produced
  `STQ_ASSERT(a_accept_quiet, (in_valid && !in_stall) |-> !res.push, "request taken mid-result")
  // only expired transfers may be non-final
  `STQ_ASSERT(a_last_kind, (out_valid && out_outcome != OUT_EXPIRED) |-> out_last,
    "single result without last")

endmodule
